// ===== src/xclfr_pkg.sv =====
// ----------------------------------------------------------------------------
// xclfr_pkg
// shared types and constants of the header/length/xor frame receiver
// ----------------------------------------------------------------------------
package xclfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int IDX_W           = 9;
    localparam int LEN_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_PAYLOAD_DEF = 512;

    localparam logic [BYTE_W-1:0] HDR_RESET = 8'hFE;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HDR = 2'd1;

    typedef enum logic [3:0] {
        PH_HUNT0 = 4'b0001,
        PH_HUNT1 = 4'b0010,
        PH_LEN   = 4'b0100,
        PH_DATA  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [BYTE_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic              frame_done;
        logic              frame_good;
        logic              frame_overflow;
        logic [LEN_W-1:0]  announced_length;
    } t_result;

endpackage

// ===== src/xclfr_rx_if.sv =====
// ----------------------------------------------------------------------------
// xclfr_rx_if
// valid/ready channel carrying one received byte per request
// ----------------------------------------------------------------------------
interface xclfr_rx_if import xclfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/xclfr_res_if.sv =====
// ----------------------------------------------------------------------------
// xclfr_res_if
// valid/ready channel carrying one receiver result per request
// ----------------------------------------------------------------------------
interface xclfr_res_if import xclfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  payload_index;
    logic              frame_done;
    logic              frame_good;
    logic              frame_overflow;
    logic [LEN_W-1:0]  announced_length;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_done, output frame_good, output frame_overflow,
        output announced_length, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input frame_done, input frame_good, input frame_overflow,
        input announced_length, output ready
    );
endinterface

// ===== src/xclfr_in_reg.sv =====
// ----------------------------------------------------------------------------
// xclfr_in_reg
// input register stage holding one received byte
// ----------------------------------------------------------------------------
module xclfr_in_reg import xclfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_ready,
    input  logic              i_adv,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== src/xclfr_core.sv =====
// ----------------------------------------------------------------------------
// xclfr_core
// header hunt, length capture and payload xor check, one byte per advance
// ----------------------------------------------------------------------------
module xclfr_core import xclfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_wr           i_cfg,
    input  logic              i_adv,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_result
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD);
    localparam logic [CNT_W:0] MAX_CNT = MAX_PAYLOAD[CNT_W:0];

    logic [BYTE_W-1:0] r_hdr0;
    logic [BYTE_W-1:0] r_hdr1;
    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_xor, n_xor;

    logic [CNT_W:0]    cnt_next;
    logic [LEN_W-1:0]  cnt_ext;
    logic [BYTE_W-1:0] xor_new;

    assign cnt_next = {1'b0, r_cnt} + {{CNT_W{1'b0}}, 1'b1};
    assign cnt_ext  = LEN_W'(r_cnt);
    assign xor_new  = r_xor ^ i_byte;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_xor    = r_xor;
        o_result = '0;
        case (r_phase)
            PH_DATA: begin
                o_result.payload_valid    = 1'b1;
                o_result.payload_byte     = i_byte;
                o_result.payload_index    = cnt_ext[IDX_W-1:0];
                o_result.announced_length = r_len;
                n_xor = xor_new;
                if (r_len <= LEN_W'(cnt_next)) begin
                    o_result.frame_done = 1'b1;
                    o_result.frame_good = (xor_new == '0);
                    n_cnt   = '0;
                    n_phase = PH_HUNT0;
                end else if (cnt_next >= MAX_CNT) begin
                    o_result.frame_overflow = 1'b1;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_phase = PH_HUNT0;
                end else begin
                    n_cnt = cnt_next[CNT_W-1:0];
                end
            end
            PH_LEN: begin
                n_len = {r_len[LEN_W-BYTE_W-1:0], i_byte};
                if (r_cnt != '0) begin
                    n_cnt   = '0;
                    n_xor   = '0;
                    n_phase = PH_DATA;
                end else begin
                    n_cnt = CNT_W'(1);
                end
            end
            PH_HUNT1: begin
                if (i_byte == r_hdr1) begin
                    n_len   = '0;
                    n_cnt   = '0;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_HUNT0;
                end
            end
            default: begin
                n_phase = (i_byte == r_hdr0) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr0 <= HDR_RESET;
            r_hdr1 <= HDR_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_FIRST_HDR:  r_hdr0 <= i_cfg.data;
                CFG_SECOND_HDR: r_hdr1 <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_xor   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_xor   <= n_xor;
        end
    end

endmodule

// ===== src/xclfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// xclfr_out_reg
// result register decoupling the core from the result channel
// ----------------------------------------------------------------------------
module xclfr_out_reg import xclfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_take,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_take   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== src/xor_checked_length_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// xor_checked_length_frame_receiver
// path: an accepted byte is held in the input register, and its core result is registered in the output register
// throughput: one byte per cycle while the result channel is ready; the core updates its state on each advance
// reset: synchronous, clears both stages, returns to header hunt, headers to 0xFE
// ----------------------------------------------------------------------------
module xor_checked_length_frame_receiver import xclfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    xclfr_rx_if.sink             i_rx,
    xclfr_res_if.source          o_res
);

    t_cfg_wr           cfg;
    logic              stg_valid;
    logic [BYTE_W-1:0] stg_byte;
    logic              take;
    logic              adv;
    t_result           core_res;
    t_result           out_res;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;
    assign adv      = stg_valid && take;

    xclfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .o_ready (i_rx.ready),
        .i_adv   (adv),
        .o_valid (stg_valid),
        .o_byte  (stg_byte)
    );

    xclfr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_adv    (adv),
        .i_byte   (stg_byte),
        .o_result (core_res)
    );

    xclfr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stg_valid),
        .i_result (core_res),
        .o_take   (take),
        .i_ready  (o_res.ready),
        .o_valid  (o_res.valid),
        .o_result (out_res)
    );

    assign o_res.payload_valid    = out_res.payload_valid;
    assign o_res.payload_byte     = out_res.payload_byte;
    assign o_res.payload_index    = out_res.payload_index;
    assign o_res.frame_done       = out_res.frame_done;
    assign o_res.frame_good       = out_res.frame_good;
    assign o_res.frame_overflow   = out_res.frame_overflow;
    assign o_res.announced_length = out_res.announced_length;

endmodule
